// ----- design/serd_pkg.sv -----
// serd_pkg: shared types and codes of the event rate discriminator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package serd_pkg;

  localparam int FUNC_W   = 2;
  localparam int STAMP_W  = 64;
  localparam int LIMIT_W  = 5;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_CNT_W = 5;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  // operation codes carried on tuser
  localparam func_t FUNC_RECORD = 2'd0;
  localparam func_t FUNC_RESET  = 2'd1;
  localparam func_t FUNC_GC     = 2'd2;
  localparam func_t FUNC_NOP    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 8'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd4;
  localparam stamp_t             WINDOW_RESET = 64'd0;

  // one result word, status after the step
  typedef struct packed {
    logic                 is_empty;
    logic [OUT_CNT_W-1:0] event_count;
    logic                 fired_state;
    logic                 fire;
  } result_t;

endpackage

// ----- design/serd_event_rate_discriminator_unit.sv -----
// serd_event_rate_discriminator_unit: top level of the event rate discriminator.
// Holds config registers and the result register; uses serd_pkg, serd_ctrl, serd_ring_ram.
`timescale 1ns / 1ps
//
// Channel   | Signals                                   | Word
// ----------+-------------------------------------------+------------------------------
// s_*       | s_tvalid s_tready s_tdata s_tuser          | tdata timestamp, tuser func
// m_*       | m_tvalid m_tready m_tdata                  | status of the finished step
// cfg_*     | cfg_valid cfg_ready cfg_index cfg_data     | 0 event_limit, 1 time_window
//
// Steps: reset, gc on an empty or fired ring, record while fired and func 3 go from idle
//   straight to output; a record word adds a compare state (ring write plus oldest-stamp read, then compare).
// A gc word on a single stamp reads the newest stamp, then outputs; on two or more it then
//   checks the oldest and drops stale entries, one per cycle, bounded by the ring read port.
// rst clears pointers, count and fired flag; ring contents need no clearing pass.
// A result waits in the output register; a new word is accepted while it waits, and
//   the sequencer holds its next result until that register frees.
// Config writes are always accepted (cfg_ready is tied high).

module serd_event_rate_discriminator_unit #(
  parameter int RING_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  serd_pkg::stamp_t                s_tdata,   // [63:0] timestamp
  input  serd_pkg::func_t                 s_tuser,   // [1:0] func
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [0] fire, [1] fired_state,
                                                     // [6:2] event_count, [7] is_empty
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [serd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  serd_pkg::stamp_t                cfg_data
);
  import serd_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  logic [LIMIT_W-1:0] event_limit;
  stamp_t             time_window;

  logic               ctrl_ready;
  logic               res_valid;
  logic               res_take;
  result_t            res;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  stamp_t             mem_wdata;
  stamp_t             mem_rdata;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_limit <= LIMIT_RESET;
      time_window <= WINDOW_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_EVENT_LIMIT) begin
        event_limit <= cfg_data[LIMIT_W-1:0];
      end else if (cfg_index == CFG_TIME_WINDOW) begin
        time_window <= cfg_data;
      end
    end
  end

  assign s_tready = ctrl_ready;

  serd_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (s_tvalid & ctrl_ready),
    .ready       (ctrl_ready),
    .func        (s_tuser),
    .timestamp   (s_tdata),
    .event_limit (event_limit),
    .time_window (time_window),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  serd_ring_ram #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_take) begin
      m_tdata <= res;
    end
  end

endmodule

// ----- design/serd_ring_ram.sv -----
// serd_ring_ram: timestamp ring storage, one write and one read port.
// Registered read data. Uses serd_pkg.
`timescale 1ns / 1ps

module serd_ring_ram #(
  parameter int RING_DEPTH = 16,
  parameter int IDX_W      = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  serd_pkg::stamp_t  wdata,
  input  logic [IDX_W-1:0]  raddr,
  output serd_pkg::stamp_t  rdata
);
  import serd_pkg::*;

  stamp_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/serd_ctrl.sv -----
// serd_ctrl: sequencer for record, reset and gc words; ring pointers and fired flag.
// Drives serd_ring_ram through its ports. Uses serd_pkg.
`timescale 1ns / 1ps

module serd_ctrl #(
  parameter int RING_DEPTH = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          ready,
  input  serd_pkg::func_t               func,
  input  serd_pkg::stamp_t              timestamp,
  input  logic [serd_pkg::LIMIT_W-1:0]  event_limit,
  input  serd_pkg::stamp_t              time_window,
  output logic                          res_valid,
  input  logic                          res_take,
  output serd_pkg::result_t             res,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output serd_pkg::stamp_t              mem_wdata,
  output logic [IDX_W-1:0]              mem_raddr,
  input  serd_pkg::stamp_t              mem_rdata
);
  import serd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REC    = 3'd1;
  localparam logic [2:0] S_GC_NEW = 3'd2;
  localparam logic [2:0] S_GC_CHK = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] oldest, oldest_next;
  logic [CNT_W-1:0] count, count_next;
  logic             fired, fired_next;
  logic             fire_r, fire_next;
  logic             may_fire, may_fire_next;
  logic             self_hit, self_hit_next;
  stamp_t           stamp, stamp_next;

  logic [CNT_W-1:0] lim, keep, drop;
  logic [IDX_W-1:0] rec_oldest, rec_wslot, gc_newest, oldest_inc;
  stamp_t           diff;

  // sum of two ring positions below twice the depth, folded back into the ring
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [CNT_W:0] v);
    logic [CNT_W:0] d;
    d = v - (CNT_W+1)'(RING_DEPTH);
    if (v >= (CNT_W+1)'(RING_DEPTH)) begin
      return d[IDX_W-1:0];
    end
    return v[IDX_W-1:0];
  endfunction

  // limit clamped to 1..RING_DEPTH
  always_comb begin
    if (event_limit == '0) begin
      lim = CNT_W'(1);
    end else if (32'(event_limit) > RING_DEPTH) begin
      lim = CNT_W'(RING_DEPTH);
    end else begin
      lim = CNT_W'(event_limit);
    end
  end

  assign keep       = (count >= lim) ? lim - CNT_W'(1) : count;
  assign drop       = count - keep;
  assign rec_oldest = wrap_slot((CNT_W+1)'(oldest) + (CNT_W+1)'(drop));
  assign rec_wslot  = wrap_slot((CNT_W+1)'(rec_oldest) + (CNT_W+1)'(keep));
  assign gc_newest  = wrap_slot((CNT_W+1)'(oldest) + (CNT_W+1)'(count) - (CNT_W+1)'(1));
  assign oldest_inc = (oldest == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest + IDX_W'(1);
  assign diff       = stamp - mem_rdata;

  always_comb begin
    state_next    = state;
    oldest_next   = oldest;
    count_next    = count;
    fired_next    = fired;
    fire_next     = fire_r;
    may_fire_next = may_fire;
    self_hit_next = self_hit;
    stamp_next    = stamp;
    mem_we        = 1'b0;
    mem_waddr     = rec_wslot;
    mem_wdata     = timestamp;
    mem_raddr     = oldest;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          fire_next  = 1'b0;
          state_next = S_OUT;
          case (func)
            FUNC_RECORD: begin
              if (!fired) begin
                mem_we        = 1'b1;
                mem_raddr     = rec_oldest;
                oldest_next   = rec_oldest;
                count_next    = keep + CNT_W'(1);
                stamp_next    = timestamp;
                may_fire_next = (keep == lim - CNT_W'(1));
                self_hit_next = (keep == '0);
                state_next    = S_REC;
              end
            end
            FUNC_RESET: begin
              oldest_next = '0;
              count_next  = '0;
              fired_next  = 1'b0;
            end
            FUNC_GC: begin
              if (count != '0 && !fired) begin
                mem_raddr  = gc_newest;
                state_next = S_GC_NEW;
              end
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_REC: begin
        // single-entry ring: oldest is the new stamp, gap is zero
        if (may_fire && (self_hit || diff <= time_window)) begin
          fired_next = 1'b1;
          fire_next  = 1'b1;
        end
        state_next = S_OUT;
      end
      S_GC_NEW: begin
        stamp_next = mem_rdata;
        mem_raddr  = oldest;
        state_next = (count > CNT_W'(1)) ? S_GC_CHK : S_OUT;
      end
      S_GC_CHK: begin
        if (count > CNT_W'(1) && diff > time_window) begin
          oldest_next = oldest_inc;
          count_next  = count - CNT_W'(1);
          mem_raddr   = oldest_inc;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      oldest <= '0;
      count  <= '0;
      fired  <= 1'b0;
      fire_r <= 1'b0;
    end else begin
      state  <= state_next;
      oldest <= oldest_next;
      count  <= count_next;
      fired  <= fired_next;
      fire_r <= fire_next;
    end
    may_fire <= may_fire_next;
    self_hit <= self_hit_next;
    stamp    <= stamp_next;
  end

  assign ready             = (state == S_IDLE);
  assign res_valid         = (state == S_OUT);
  assign res.fire          = fire_r;
  assign res.fired_state   = fired;
  assign res.event_count   = OUT_CNT_W'(count);
  assign res.is_empty      = (count == '0);

endmodule
